// ===== hdl/brfsc_pkg.sv =====
`default_nettype none

package brfsc_pkg;

    localparam int DATA_W = 8;
    localparam int OP_W = 2;
    localparam int CAP_W = 11;
    localparam int LEN_W = 11;
    localparam int COUNT_W = 7;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int MAX_READ_RUN_DEF = 64;
    localparam int CAP_RESET = 1024;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_COMMIT = 2'd1,
        OP_GET    = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  data;
        logic               first;
        logic [LEN_W-1:0]   length;
        logic [COUNT_W-1:0] count;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/brfsc_ram.sv =====
`default_nettype none

module brfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/brfsc_front.sv =====
`default_nettype none

module brfsc_front #(
    parameter int MAX_READ_RUN = brfsc_pkg::MAX_READ_RUN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [brfsc_pkg::OP_W-1:0]    operation,
    input  wire logic [brfsc_pkg::DATA_W-1:0]  data_in,
    input  wire logic                          chunk_first,
    input  wire logic [brfsc_pkg::LEN_W-1:0]   chunk_length,
    input  wire logic [brfsc_pkg::COUNT_W-1:0] read_count,
    output logic                               q_valid,
    output brfsc_pkg::item_t                   q_item,
    input  wire logic                          pop
);

    localparam int QD = brfsc_pkg::QUEUE_DEPTH;
    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    brfsc_pkg::item_t entry_reg [QD];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    logic accept;
    brfsc_pkg::item_t new_item;

    assign busy = (count_reg == QCW'(QD));
    assign accept = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item = entry_reg[rd_ptr_reg];

    // The read run length is capped here so the back end only compares with the count.
    always_comb
    begin
        new_item.op = brfsc_pkg::op_t'(operation);
        new_item.data = data_in;
        new_item.first = chunk_first;
        new_item.length = chunk_length;
        if (32'(read_count) > MAX_READ_RUN)
        begin
            new_item.count = brfsc_pkg::COUNT_W'(MAX_READ_RUN);
        end
        else
        begin
            new_item.count = read_count;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !(pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/brfsc_back.sv =====
`default_nettype none

module brfsc_back #(
    parameter int RING_DEPTH = brfsc_pkg::RING_DEPTH_DEF,
    parameter int MAX_READ_RUN = brfsc_pkg::MAX_READ_RUN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire brfsc_pkg::item_t             q_item,
    output logic                              pop,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [brfsc_pkg::CAP_W-1:0]  cfg_data,
    output logic                              result_valid,
    output logic [brfsc_pkg::DATA_W-1:0]      data_out,
    output logic                              byte_valid,
    output logic                              last_of_run,
    output logic                              overflow,
    output logic [brfsc_pkg::CAP_W-1:0]       committed_count,
    output logic [brfsc_pkg::CAP_W-1:0]       free_space
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CAP_MAX = (RING_DEPTH < 2047) ? RING_DEPTH : 2047;
    localparam int CW = $clog2(CAP_MAX + 1);
    localparam int PW = (AW < CW) ? AW : CW;
    localparam int RW = $clog2(MAX_READ_RUN + 1);
    localparam int XW = brfsc_pkg::CAP_W + 1;
    localparam int CAP_RST_INT =
        (brfsc_pkg::CAP_RESET > CAP_MAX) ? CAP_MAX : brfsc_pkg::CAP_RESET;

    brfsc_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0] cap_reg, cap_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] cp_reg, cp_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic          drop_reg, drop_next;
    logic [PW-1:0] run_ptr_reg, run_ptr_next;
    logic [RW-1:0] remain_reg, remain_next;
    logic          run_get_reg, run_get_next;

    logic                            res_valid_reg, res_valid_next;
    logic                            res_byte_reg, res_byte_next;
    logic                            res_last_reg, res_last_next;
    logic                            res_ovf_reg, res_ovf_next;
    logic [brfsc_pkg::CAP_W-1:0]     res_cnt_reg, res_cnt_next;
    logic [brfsc_pkg::CAP_W-1:0]     res_free_reg, res_free_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [brfsc_pkg::DATA_W-1:0] ram_rdata;

    logic [CW-1:0] cnt_now;
    logic [CW-1:0] sf_now;
    logic [CW-1:0] cnt_commit;
    logic [CW-1:0] cnt_after;
    logic [RW-1:0] run_n;
    logic          is_read;
    logic          drop_first;
    logic          drop_put;
    logic          cfg_fire;

    function automatic logic [CW-1:0] ring_dist(input logic [PW-1:0] a,
                                                input logic [PW-1:0] b,
                                                input logic [CW-1:0] cap);
        logic [CW:0] d;
        if (b >= a)
        begin
            d = (CW+1)'(b) - (CW+1)'(a);
        end
        else
        begin
            d = (CW+1)'(cap) + (CW+1)'(b) - (CW+1)'(a);
        end
        return d[CW-1:0];
    endfunction

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [CW-1:0] cap);
        logic [CW:0] inc;
        inc = (CW+1)'(p) + 1'b1;
        if (inc >= (CW+1)'(cap))
        begin
            return '0;
        end
        return inc[PW-1:0];
    endfunction

    brfsc_ram #(
        .WIDTH(brfsc_pkg::DATA_W),
        .DEPTH(RING_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(q_item.data),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cnt_now = ring_dist(rp_reg, cp_reg, cap_reg);
    assign sf_now = cap_reg - ring_dist(rp_reg, sp_reg, cap_reg);
    assign cnt_commit = ring_dist(rp_reg, sp_reg, cap_reg);
    assign is_read = (q_item.op == brfsc_pkg::OP_GET) || (q_item.op == brfsc_pkg::OP_PEEK);

    // A rejected chunk keeps dropping until the next first byte; any byte also
    // needs more than the one slot that is always kept empty.
    assign drop_first = q_item.first ? (XW'(sf_now) <= XW'(q_item.length)) : drop_reg;
    assign drop_put = drop_first || (sf_now <= CW'(1));

    always_comb
    begin
        if (XW'(q_item.count) > XW'(cnt_now))
        begin
            run_n = RW'(cnt_now);
        end
        else
        begin
            run_n = RW'(q_item.count);
        end
    end

    assign cnt_after = (q_item.op == brfsc_pkg::OP_GET) ? cnt_now - CW'(run_n) : cnt_now;

    assign cfg_ready = (state_reg == brfsc_pkg::BK_IDLE) && !q_valid;
    assign cfg_fire = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brfsc_pkg::BK_IDLE:
            begin
                if (q_valid && is_read && (run_n > RW'(1)))
                begin
                    state_next = brfsc_pkg::BK_RUN;
                end
            end
            brfsc_pkg::BK_RUN:
            begin
                if (remain_reg == RW'(1))
                begin
                    state_next = brfsc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = brfsc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next = cap_reg;
        rp_next = rp_reg;
        cp_next = cp_reg;
        sp_next = sp_reg;
        drop_next = drop_reg;
        run_ptr_next = run_ptr_reg;
        remain_next = remain_reg;
        run_get_next = run_get_reg;
        res_valid_next = 1'b0;
        res_byte_next = res_byte_reg;
        res_last_next = res_last_reg;
        res_ovf_next = res_ovf_reg;
        res_cnt_next = res_cnt_reg;
        res_free_next = res_free_reg;
        pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = AW'(sp_reg);
        ram_re = 1'b0;
        ram_raddr = AW'(rp_reg);

        case (state_reg)
            brfsc_pkg::BK_IDLE:
            begin
                if (cfg_fire)
                begin
                    if (cfg_data < brfsc_pkg::CAP_W'(2))
                    begin
                        cap_next = CW'(2);
                    end
                    else if (32'(cfg_data) > CAP_MAX)
                    begin
                        cap_next = CW'(CAP_MAX);
                    end
                    else
                    begin
                        cap_next = CW'(cfg_data);
                    end
                    rp_next = '0;
                    cp_next = '0;
                    sp_next = '0;
                    drop_next = 1'b0;
                end
                else if (q_valid)
                begin
                    pop = 1'b1;
                    res_valid_next = 1'b1;
                    res_byte_next = 1'b0;
                    res_last_next = 1'b1;
                    res_ovf_next = 1'b0;
                    res_cnt_next = brfsc_pkg::CAP_W'(cnt_now);
                    res_free_next = brfsc_pkg::CAP_W'(cap_reg - cnt_now);
                    case (q_item.op)
                        brfsc_pkg::OP_PUT:
                        begin
                            drop_next = drop_put;
                            res_ovf_next = drop_put;
                            if (!drop_put)
                            begin
                                ram_we = 1'b1;
                                sp_next = advance(sp_reg, cap_reg);
                            end
                        end
                        brfsc_pkg::OP_COMMIT:
                        begin
                            cp_next = sp_reg;
                            res_cnt_next = brfsc_pkg::CAP_W'(cnt_commit);
                            res_free_next = brfsc_pkg::CAP_W'(cap_reg - cnt_commit);
                        end
                        brfsc_pkg::OP_GET, brfsc_pkg::OP_PEEK:
                        begin
                            res_cnt_next = brfsc_pkg::CAP_W'(cnt_after);
                            res_free_next = brfsc_pkg::CAP_W'(cap_reg - cnt_after);
                            if (run_n != '0)
                            begin
                                ram_re = 1'b1;
                                ram_raddr = AW'(rp_reg);
                                res_byte_next = 1'b1;
                                res_last_next = (run_n == RW'(1));
                                run_ptr_next = advance(rp_reg, cap_reg);
                                remain_next = run_n - 1'b1;
                                run_get_next = (q_item.op == brfsc_pkg::OP_GET);
                                if (q_item.op == brfsc_pkg::OP_GET)
                                begin
                                    rp_next = advance(rp_reg, cap_reg);
                                end
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            brfsc_pkg::BK_RUN:
            begin
                ram_re = 1'b1;
                ram_raddr = AW'(run_ptr_reg);
                res_valid_next = 1'b1;
                res_byte_next = 1'b1;
                res_last_next = (remain_reg == RW'(1));
                run_ptr_next = advance(run_ptr_reg, cap_reg);
                remain_next = remain_reg - 1'b1;
                if (run_get_reg)
                begin
                    rp_next = advance(run_ptr_reg, cap_reg);
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brfsc_pkg::BK_IDLE;
            cap_reg <= CW'(CAP_RST_INT);
            rp_reg <= '0;
            cp_reg <= '0;
            sp_reg <= '0;
            drop_reg <= 1'b0;
            remain_reg <= '0;
            run_get_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg <= cap_next;
            rp_reg <= rp_next;
            cp_reg <= cp_next;
            sp_reg <= sp_next;
            drop_reg <= drop_next;
            remain_reg <= remain_next;
            run_get_reg <= run_get_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_ptr_reg <= run_ptr_next;
        res_byte_reg <= res_byte_next;
        res_last_reg <= res_last_next;
        res_ovf_reg <= res_ovf_next;
        res_cnt_reg <= res_cnt_next;
        res_free_reg <= res_free_next;
    end

    assign result_valid = res_valid_reg;
    assign data_out = res_byte_reg ? ram_rdata : '0;
    assign byte_valid = res_byte_reg;
    assign last_of_run = res_last_reg;
    assign overflow = res_ovf_reg;
    assign committed_count = res_cnt_reg;
    assign free_space = res_free_reg;

endmodule

`default_nettype wire

// ===== hdl/byte_ring_fifo_staged_commit.sv =====
// An accepted item is queued; the executing stage pops it when idle and registers its result.
// A get or peek returns up to its count of committed bytes (at most 64) and holds the
// executing stage for the whole run, one byte per cycle from the registered store port.
// A two-entry queue sits between the accepting and executing stages; busy means it is full.
// Reset clears all pointers and sets the capacity to 1024 slots; stored bytes are undefined.
// Results cannot be stalled by the receiver.
`default_nettype none

module byte_ring_fifo_staged_commit #(
    parameter int RING_DEPTH = brfsc_pkg::RING_DEPTH_DEF,
    parameter int MAX_READ_RUN = brfsc_pkg::MAX_READ_RUN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [brfsc_pkg::OP_W-1:0]    operation,
    input  wire logic [brfsc_pkg::DATA_W-1:0]  data_in,
    input  wire logic                          chunk_first,
    input  wire logic [brfsc_pkg::LEN_W-1:0]   chunk_length,
    input  wire logic [brfsc_pkg::COUNT_W-1:0] read_count,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [brfsc_pkg::CAP_W-1:0]   cfg_data,
    output logic                               result_valid,
    output logic [brfsc_pkg::DATA_W-1:0]       data_out,
    output logic                               byte_valid,
    output logic                               last_of_run,
    output logic                               overflow,
    output logic [brfsc_pkg::CAP_W-1:0]        committed_count,
    output logic [brfsc_pkg::CAP_W-1:0]        free_space
);

    logic             q_valid;
    brfsc_pkg::item_t q_item;
    logic             pop;

    brfsc_front #(
        .MAX_READ_RUN(MAX_READ_RUN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .data_in     (data_in),
        .chunk_first (chunk_first),
        .chunk_length(chunk_length),
        .read_count  (read_count),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop)
    );

    brfsc_back #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_READ_RUN(MAX_READ_RUN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .data_out       (data_out),
        .byte_valid     (byte_valid),
        .last_of_run    (last_of_run),
        .overflow       (overflow),
        .committed_count(committed_count),
        .free_space     (free_space)
    );

`ifndef ASSERT_OFF
    // A read run is delivered without gaps.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |=> result_valid)
        else $error("read run broken before its last item");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> (data_out == '0) && last_of_run)
        else $error("empty result carries data or is not last");

    a_overflow_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflow |-> !byte_valid && last_of_run)
        else $error("overflow flagged on a byte result");

    a_cfg_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy && !q_valid)
        else $error("configuration offered while items are queued");
`endif

endmodule

`default_nettype wire
